### hdl/c2mp_pkg.sv
// ----------------------------------------------------------------------------
// c2mp_pkg: shared types and constants
// Widths, arctangent table and pipeline control types for the rectangular to
// polar converter.
// ----------------------------------------------------------------------------
package c2mp_pkg;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int GUARD_BITS    = 16;
	localparam int ATAN_ENTRIES  = 32;

	// four bits of headroom for the CORDIC gain and the pi pre-rotation
	localparam int DATA_W  = SAMPLE_WIDTH + GUARD_BITS + 4;
	localparam int ANGLE_W = 32;
	localparam int PHASE_W = 16;
	localparam int MAG_W   = 16;

	// inverse CORDIC gain, Q32
	localparam int GAIN_W = 32;
	localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131497;

	// gain removal: magnitude = (x * INV_GAIN + half) >> (GAIN_W + GUARD_BITS)
	localparam int UX_W       = DATA_W - 1;
	localparam int LO_W       = 16;
	localparam int HI_W       = UX_W - LO_W;
	localparam int PROD_SHIFT = GAIN_W + GUARD_BITS;
	localparam int SUM_W      = HI_W + GAIN_W + LO_W + 1;

	// accepting edge to the edge that loads the result registers
	localparam int LATENCY = CORDIC_STAGES + 2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [ANGLE_W-1:0] angle_t;

	typedef struct packed {
		logic valid;
		logic zero;
		logic block_end;
	} ctrl_t;

	typedef struct packed {
		data_t  x;
		data_t  y;
		angle_t angle;
	} vec_t;

	// atan(2^-k) with 2^32 = 2*pi, truncated
	localparam angle_t ATAN_LUT [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	localparam angle_t ANGLE_PI = 32'h80000000;

endpackage

### hdl/complex_to_magnitude_phase.sv
// Pipeline: an accepted item passes the input stage, one stage per micro-rotation,
//   the product stage and the output stage before it shows on done.
// Throughput: one item per cycle; busy stays low and start is taken every cycle.
// The result is valid for one cycle on done; the receiver cannot stall.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
// complex_to_magnitude_phase: CORDIC rectangular to polar converter
// Returns rounded magnitude and phase (32768 = pi) of a signed I/Q sample.
// ----------------------------------------------------------------------------
module complex_to_magnitude_phase (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0] i_sample,
	input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0] q_sample,
	input  logic                                     block_end,
	output logic                                     done,
	output logic        [c2mp_pkg::MAG_W-1:0]        magnitude,
	output logic signed [c2mp_pkg::PHASE_W-1:0]      phase,
	output logic                                     block_end_out
);
	import c2mp_pkg::*;

	logic  accept;
	vec_t  pre_vec;
	ctrl_t pre_ctrl;
	vec_t  rot_vec;
	ctrl_t rot_ctrl;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	c2mp_prerot u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.i_sample  (i_sample),
		.q_sample  (q_sample),
		.block_end (block_end),
		.vec_s1    (pre_vec),
		.ctrl_s1   (pre_ctrl)
	);

	c2mp_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec_in   (pre_vec),
		.ctrl_in  (pre_ctrl),
		.vec_out  (rot_vec),
		.ctrl_out (rot_ctrl)
	);

	c2mp_gain u_gain (
		.clk           (clk),
		.arst_n        (arst_n),
		.vec_in        (rot_vec),
		.ctrl_in       (rot_ctrl),
		.magnitude     (magnitude),
		.phase         (phase),
		.block_end_out (block_end_out),
		.done          (done)
	);

	// the result registers load at the edge that LATENCY measures from accept, and the checks sample them after that edge
`ifndef ASSERT_OFF
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LATENCY + 1) done)
		else $error("accepted item produced no result");

	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY + 1))
		else $error("result without an accepted item");

	a_zero_in: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && i_sample == '0 && q_sample == '0)
		|-> ##(LATENCY + 1) (magnitude == '0 && phase == '0))
		else $error("zero sample gave nonzero result");

	a_flag_passes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LATENCY + 1) (block_end_out == $past(block_end, LATENCY + 1)))
		else $error("block end flag lost");
`endif

endmodule

### hdl/c2mp_prerot.sv
// ----------------------------------------------------------------------------
// c2mp_prerot: input stage
// Registers the sample with guard bits and rotates the left half plane by pi.
// ----------------------------------------------------------------------------
module c2mp_prerot (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0] i_sample,
	input  logic signed [c2mp_pkg::SAMPLE_WIDTH-1:0] q_sample,
	input  logic                                    block_end,
	output c2mp_pkg::vec_t                          vec_s1,
	output c2mp_pkg::ctrl_t                         ctrl_s1
);
	import c2mp_pkg::*;

	data_t xi;
	data_t yi;
	logic  neg;

	assign xi  = data_t'(i_sample) <<< GUARD_BITS;
	assign yi  = data_t'(q_sample) <<< GUARD_BITS;
	assign neg = i_sample[SAMPLE_WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid     <= load;
			ctrl_s1.zero      <= (i_sample == '0) && (q_sample == '0);
			ctrl_s1.block_end <= block_end;
		end
	end

	always_ff @(posedge clk) begin
		if (neg) begin
			vec_s1.x     <= -xi;
			vec_s1.y     <= -yi;
			vec_s1.angle <= ANGLE_PI;
		end else begin
			vec_s1.x     <= xi;
			vec_s1.y     <= yi;
			vec_s1.angle <= '0;
		end
	end

endmodule

### hdl/c2mp_cordic.sv
// ----------------------------------------------------------------------------
// c2mp_cordic: vectoring pipeline
// One shift-and-add micro-rotation per register stage, driving y to zero and
// summing the rotation angles.
// ----------------------------------------------------------------------------
module c2mp_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  c2mp_pkg::vec_t  vec_in,
	input  c2mp_pkg::ctrl_t ctrl_in,
	output c2mp_pkg::vec_t  vec_out,
	output c2mp_pkg::ctrl_t ctrl_out
);
	import c2mp_pkg::*;

	vec_t  rot_s  [CORDIC_STAGES];
	ctrl_t ctrl_s [CORDIC_STAGES];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		vec_t  src;
		ctrl_t csrc;
		data_t sx;
		data_t sy;
		logic  up;

		if (k == 0) begin : g_first
			assign src  = vec_in;
			assign csrc = ctrl_in;
		end else begin : g_next
			assign src  = rot_s[k-1];
			assign csrc = ctrl_s[k-1];
		end

		assign sx = src.x;
		assign sy = src.y;
		// rotate clockwise while y is still non-negative
		assign up = !sy[DATA_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_s[k] <= '0;
			end else begin
				ctrl_s[k] <= csrc;
			end
		end

		always_ff @(posedge clk) begin
			if (up) begin
				rot_s[k].x     <= sx + (sy >>> k);
				rot_s[k].y     <= sy - (sx >>> k);
				rot_s[k].angle <= src.angle + ATAN_LUT[k];
			end else begin
				rot_s[k].x     <= sx - (sy >>> k);
				rot_s[k].y     <= sy + (sx >>> k);
				rot_s[k].angle <= src.angle - ATAN_LUT[k];
			end
		end
	end

	assign vec_out  = rot_s[CORDIC_STAGES-1];
	assign ctrl_out = ctrl_s[CORDIC_STAGES-1];

endmodule

### hdl/c2mp_gain.sv
// ----------------------------------------------------------------------------
// c2mp_gain: gain removal and output stage
// Scales x by the inverse CORDIC gain in two partial products, rounds and
// saturates the magnitude, rounds the phase and registers the result.
// ----------------------------------------------------------------------------
module c2mp_gain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  c2mp_pkg::vec_t                      vec_in,
	input  c2mp_pkg::ctrl_t                     ctrl_in,
	output logic        [c2mp_pkg::MAG_W-1:0]   magnitude,
	output logic signed [c2mp_pkg::PHASE_W-1:0] phase,
	output logic                                block_end_out,
	output logic                                done
);
	import c2mp_pkg::*;

	logic [UX_W-1:0]           ux;
	angle_t                    angle_rnd;
	logic [LO_W+GAIN_W-1:0]    p_lo_s1;
	logic [HI_W+GAIN_W-1:0]    p_hi_s1;
	logic [PHASE_W-1:0]        phase_s1;
	ctrl_t                     ctrl_s1;
	logic [SUM_W-1:0]          sum;
	logic [SUM_W-PROD_SHIFT-1:0] mag_full;

	// negative x reads as zero
	assign ux        = vec_in.x[DATA_W-1] ? '0 : vec_in.x[UX_W-1:0];
	assign angle_rnd = vec_in.angle + (angle_t'(1) << (ANGLE_W - PHASE_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			done    <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl_in;
			done    <= ctrl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		p_lo_s1  <= ux[LO_W-1:0] * INV_GAIN;
		p_hi_s1  <= ux[UX_W-1:LO_W] * INV_GAIN;
		phase_s1 <= ctrl_in.zero ? '0 : angle_rnd[ANGLE_W-1 -: PHASE_W];
	end

	assign sum = SUM_W'({p_hi_s1, {LO_W{1'b0}}}) + SUM_W'(p_lo_s1)
	           + (SUM_W'(1) << (PROD_SHIFT - 1));
	assign mag_full = sum[SUM_W-1:PROD_SHIFT];

	always_ff @(posedge clk) begin
		if (ctrl_s1.zero) begin
			magnitude <= '0;
		end else if (mag_full > (SUM_W-PROD_SHIFT)'({MAG_W{1'b1}})) begin
			magnitude <= '1;
		end else begin
			magnitude <= mag_full[MAG_W-1:0];
		end
		phase         <= phase_s1;
		block_end_out <= ctrl_s1.block_end;
	end

endmodule

### dv/complex_to_magnitude_phase_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_to_magnitude_phase_tb: regression for the CORDIC polar converter
// Drives I/Q samples with random gaps and in gapless streams, predicts magnitude, phase and the
// block-end flag with an independent fixed-point CORDIC model, and checks
// every result in order against the predicted queue.
// ----------------------------------------------------------------------------
module complex_to_magnitude_phase_tb;

	import c2mp_pkg::*;

	localparam int    CLK_HALF     = 5;
	localparam int    CYCLE_LIMIT  = 200000;
	localparam int    MAX_REPORTS  = 10;
	localparam int    FRAC_BITS    = 16;
	localparam logic [31:0]  HALF_TURN = 32'h80000000;
	localparam logic [127:0] INV_K_Q32 = 128'd2608131497;

	// atan(2^-k), 2^32 = 2*pi, truncated
	localparam logic [31:0] ARCTAN_STEP [16] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
	};

	typedef struct {
		logic        [MAG_W-1:0]   mag;
		logic signed [PHASE_W-1:0] ang;
		logic                      last;
	} polar_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] i_sample = '0;
	logic signed [SAMPLE_WIDTH-1:0] q_sample = '0;
	logic block_end = 1'b0;
	logic busy;
	logic done;
	logic        [MAG_W-1:0]   magnitude;
	logic signed [PHASE_W-1:0] phase;
	logic                      block_end_out;

	polar_t pending_polar [$];
	int mismatch_count = 0;
	int cycle_count = 0;

	complex_to_magnitude_phase dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.i_sample     (i_sample),
		.q_sample     (q_sample),
		.block_end    (block_end),
		.done         (done),
		.magnitude    (magnitude),
		.phase        (phase),
		.block_end_out(block_end_out)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Vectoring CORDIC: rotate into the right half plane, then drive y to zero.
	function automatic polar_t predict_polar(logic signed [SAMPLE_WIDTH-1:0] i_in,
			logic signed [SAMPLE_WIDTH-1:0] q_in, logic last_in);
		longint x;
		longint y;
		longint dx;
		longint dy;
		logic [31:0]  acc;
		logic [31:0]  rounded;
		logic [127:0] prod;
		logic [127:0] mag_w;
		polar_t r;
		x = i_in;
		y = q_in;
		acc = '0;
		mag_w = '0;
		if (x != 0 || y != 0) begin
			x = x <<< FRAC_BITS;
			y = y <<< FRAC_BITS;
			if (x < 0) begin
				x = -x;
				y = -y;
				acc = HALF_TURN;
			end
			for (int k = 0; k < CORDIC_STAGES && k < 16; k++) begin
				dx = y >>> k;
				dy = x >>> k;
				if (y >= 0) begin
					x = x + dx;
					y = y - dy;
					acc = acc + ARCTAN_STEP[k];
				end else begin
					x = x - dx;
					y = y + dy;
					acc = acc - ARCTAN_STEP[k];
				end
			end
			if (x > 0) begin
				prod = 128'(unsigned'(x)) * INV_K_Q32 + (128'd1 << (32 + FRAC_BITS - 1));
				mag_w = prod >> (32 + FRAC_BITS);
			end
			if (mag_w > 128'd65535)
				mag_w = 128'd65535;
		end
		rounded = acc + 32'h00008000;
		r.mag = mag_w[MAG_W-1:0];
		r.ang = rounded[31:16];
		r.last = last_in;
		return r;
	endfunction

	// Hold fields and start until the item is taken; start stays high afterwards.
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] i_val,
			input logic signed [SAMPLE_WIDTH-1:0] q_val, input logic last_val);
		i_sample  <= i_val;
		q_sample  <= q_val;
		block_end <= last_val;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		pending_polar.push_back(predict_polar(i_val, q_val, last_val));
	endtask

	// Drop start and put noise on the fields for the length of the gap.
	task automatic hold_off(input int n);
		if (n > 0) begin
			start     <= 1'b0;
			i_sample  <= SAMPLE_WIDTH'($urandom);
			q_sample  <= SAMPLE_WIDTH'($urandom);
			block_end <= 1'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] small_value();
		return SAMPLE_WIDTH'($urandom_range(0, 32)) - SAMPLE_WIDTH'(16);
	endfunction

	task automatic test_directed();
		logic signed [SAMPLE_WIDTH-1:0] max_p;
		logic signed [SAMPLE_WIDTH-1:0] max_n;
		max_p = 16'sh7FFF;
		max_n = 16'sh8000;
		send_sample(0, 0, 1'b0);           // zero vector
		send_sample(max_p, 0, 1'b1);
		send_sample(max_n, 0, 1'b0);       // negative real axis, angle pi
		send_sample(-1, 0, 1'b1);
		send_sample(1, 0, 1'b0);
		send_sample(0, max_p, 1'b0);
		send_sample(0, max_n, 1'b1);
		send_sample(0, 1, 1'b0);
		send_sample(0, -1, 1'b0);
		send_sample(max_p, max_p, 1'b0);
		send_sample(max_n, max_n, 1'b1);   // largest magnitude
		send_sample(max_n, max_p, 1'b0);
		send_sample(max_p, max_n, 1'b0);
		send_sample(max_n, -1, 1'b0);      // just above pi
		send_sample(max_n, 1, 1'b1);       // just below pi
		send_sample(-1, -1, 1'b0);
		send_sample(1, 1, 1'b0);
		send_sample(16'sh5555, 16'shAAAA, 1'b1);
		send_sample(16'shAAAA, 16'sh5555, 1'b0);
		hold_off(pick_gap());
		send_sample(0, 0, 1'b1);
	endtask

	task automatic test_random_full(input int n);
		for (int k = 0; k < n; k++) begin
			send_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom), 1'($urandom));
			hold_off(pick_gap());
		end
	endtask

	// Small vectors, axis cases and anti-diagonals, where rounding and quadrant handling matter most.
	task automatic test_small_and_axes(input int n);
		logic signed [SAMPLE_WIDTH-1:0] a;
		logic signed [SAMPLE_WIDTH-1:0] b;
		for (int k = 0; k < n; k++) begin
			a = SAMPLE_WIDTH'($urandom);
			case ($urandom_range(0, 3))
				0: begin
					a = small_value();
					b = small_value();
				end
				1: b = 0;
				2: begin
					b = a;
					a = 0;
				end
				default: b = -a;
			endcase
			send_sample(a, b, 1'($urandom));
			hold_off(pick_gap());
		end
	endtask

	// Full rate stream with no idle cycles.
	task automatic test_streaming(input int n);
		for (int k = 0; k < n; k++)
			send_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom), 1'(k % 7 == 6));
		hold_off(pick_gap());
	endtask

	always @(posedge clk) begin
		polar_t want;
		if (arst_n && done) begin
			if (pending_polar.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: mag %0d phase %0d last %0b",
						magnitude, phase, block_end_out);
			end else begin
				want = pending_polar.pop_front();
				if (magnitude !== want.mag || phase !== want.ang
						|| block_end_out !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected mag %0d phase %0d last %0b, got mag %0d phase %0d last %0b",
							want.mag, want.ang, want.last, magnitude, phase, block_end_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("complex_to_magnitude_phase regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_full(200);
		test_small_and_axes(130);
		test_streaming(100);
		start <= 1'b0;
		while (pending_polar.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("complex_to_magnitude_phase regression: pass");
		else
			$display("complex_to_magnitude_phase regression: fail");
		$finish;
	end

endmodule
